FILE: rtl/gsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants for the gas sensor ppm converter.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int CODE_W = 16;

  localparam logic [1:0] REG_MIN_VALID_CODE = 2'd0;
  localparam logic [1:0] REG_CAL_PPM        = 2'd1;
  localparam logic [1:0] REG_CURVE_EXPONENT = 2'd2;
  localparam logic [1:0] REG_SUPPLY_CODE_X2 = 2'd3;

  localparam logic [9:0]  RST_MIN_VALID_CODE = 10'd15;
  localparam logic [13:0] RST_CAL_PPM        = 14'd20;
  localparam logic [14:0] RST_CURVE_EXPONENT = 15'd8495;
  localparam logic [12:0] RST_SUPPLY_CODE_X2 = 13'd3103;

  localparam logic [1:0] ST_MEASURED   = 2'd0;
  localparam logic [1:0] ST_NO_SENSOR  = 2'd1;
  localparam logic [1:0] ST_CALIBRATED = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] code;
    logic              usable;
  } item_t;

  typedef struct packed {
    logic [13:0] cal_ppm;
    logic [14:0] curve_exponent_q12;
    logic [12:0] supply_code_x2;
  } cfg_t;

endpackage

FILE: rtl/gsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_front
// Accepts samples, classifies them against the threshold and holds them
// in a two-entry queue for the compute engine.
// ----------------------------------------------------------------------------
module gsp_front import gsp_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                mode,
  input  logic [ADC_BITS-1:0] adc_code,
  input  logic                read_failed,
  input  logic [9:0]          min_valid_code,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      in_item;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    in_item.mode   = mode;
    in_item.code   = CODE_W'(adc_code);
    in_item.usable = !read_failed && (CODE_W'(adc_code) > CODE_W'(min_valid_code));
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/gsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_back
// Sequenced compute engine: resistance division, fixed-point log2 of the
// reference and sample, exponent scaling, exp2 by repeated square roots,
// and the final scaling into Q24.8 with saturation.
// ----------------------------------------------------------------------------
module gsp_back import gsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_pop,
  output logic [31:0] out_ppm,
  output logic [1:0]  out_status,
  output logic        out_cal
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV      = 4'd1;
  localparam logic [3:0] S_POST     = 4'd2;
  localparam logic [3:0] S_LOG      = 4'd3;
  localparam logic [3:0] S_TMUL     = 4'd4;
  localparam logic [3:0] S_EXP_INIT = 4'd5;
  localparam logic [3:0] S_EXP      = 4'd6;
  localparam logic [3:0] S_MUL      = 4'd7;
  localparam logic [3:0] S_SHIFT    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]        state;
  logic              mode_r;
  logic [CODE_W-1:0] code_r;
  logic [CODE_W-1:0] rem;
  logic [27:0]       quo;
  logic [4:0]        cnt;
  logic [23:0]       ref_res;
  logic              ref_valid;
  logic [23:0]       rs;
  logic              log_phase;
  logic [30:0]       m;
  logic [4:0]        lp;
  logic [15:0]       frac;
  logic [20:0]       lr;
  logic [20:0]       ls;
  logic              neg;
  logic [7:0]        ip;
  logic [15:0]       f;
  logic [15:0]       ef;
  logic [3:0]        k;
  logic [31:0]       rr;
  logic [63:0]       rad;
  logic [63:0]       res;
  logic [63:0]       bitv;
  logic [45:0]       prod;
  logic [31:0]       r_ppm;
  logic [1:0]        r_status;

  logic [16:0] two_code;
  logic [27:0] num;
  logic [CODE_W:0] trial;
  logic        ge;
  logic [23:0] rs_sat;
  logic [23:0] log_x;
  logic [61:0] sq;
  logic [31:0] sq_hi;
  logic [20:0] lr_fin;
  logic        t_neg;
  logic [20:0] dmag;
  logic [35:0] tprod;
  logic [23:0] t;
  logic [32:0] ev;
  logic [63:0] rad_a, res_a, rad_b, res_b;
  logic [63:0] wv;
  logic [8:0]  rsh;
  logic [4:0]  sh;
  logic [31:0] ppm_val;

  function automatic logic [4:0] msb24(input logic [23:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  always_comb begin
    two_code = 17'({code_r, 1'b0});
    num      = {cfg.supply_code_x2 - 13'({q_item.code, 1'b0}), 15'd0};
    trial    = {rem, quo[27]} - {1'b0, code_r};
    ge       = ({rem, quo[27]} >= {1'b0, code_r});
    rs_sat   = (quo > 28'hFFFFFF) ? 24'hFFFFFF : quo[23:0];
    log_x    = (ref_valid && !mode_r) ? ref_res : rs_sat;
    sq       = 62'(m) * 62'(m);
    sq_hi    = sq[61:30];
    lr_fin   = {lp, frac[14:0], sq_hi[31]};
    t_neg    = (lr < ls);
    dmag     = t_neg ? (ls - lr) : (lr - ls);
    tprod    = 36'(dmag) * 36'(cfg.curve_exponent_q12);
    t        = tprod[35:12];
    ev       = ef[k] ? {rr, 1'b0} : {1'b0, rr};
    if (rad >= res + bitv) begin
      rad_a = rad - (res + bitv);
      res_a = (res >> 1) + bitv;
    end else begin
      rad_a = rad;
      res_a = res >> 1;
    end
    if (rad_a >= res_a + (bitv >> 2)) begin
      rad_b = rad_a - (res_a + (bitv >> 2));
      res_b = (res_a >> 1) + (bitv >> 2);
    end else begin
      rad_b = rad_a;
      res_b = res_a >> 1;
    end
    rsh = (f == 16'd0) ? (9'd22 + 9'(ip)) : (9'd23 + 9'(ip));
    sh  = 5'(ip - 8'd22);
    wv  = 64'd0;
    ppm_val = 32'd0;
    if (!neg) begin
      if (prod == 46'd0) begin
        ppm_val = 32'd0;
      end else if (ip >= 8'd22) begin
        if ((ip - 8'd22) >= 8'd19) begin
          ppm_val = 32'hFFFFFFFF;
        end else begin
          wv = 64'(prod) << sh;
          ppm_val = (wv[63:32] != 32'd0) ? 32'hFFFFFFFF : wv[31:0];
        end
      end else begin
        wv = 64'(prod) >> (5'd22 - 5'(ip));
        ppm_val = (wv[63:32] != 32'd0) ? 32'hFFFFFFFF : wv[31:0];
      end
    end else begin
      if (rsh >= 9'd64) begin
        ppm_val = 32'd0;
      end else begin
        wv = 64'(prod) >> rsh[5:0];
        ppm_val = (wv[63:32] != 32'd0) ? 32'hFFFFFFFF : wv[31:0];
      end
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ref_valid <= 1'b0;
      ref_res   <= 24'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            mode_r <= q_item.mode;
            code_r <= q_item.code;
            rem    <= '0;
            quo    <= num;
            cnt    <= 5'd27;
            if (!q_item.usable ||
                (17'(cfg.supply_code_x2) <= 17'({q_item.code, 1'b0}))) begin
              r_ppm    <= 32'd0;
              r_status <= ST_NO_SENSOR;
              if (q_item.mode) begin
                ref_valid <= 1'b0;
                ref_res   <= 24'd0;
              end
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem <= ge ? trial[CODE_W-1:0] : {rem[CODE_W-2:0], quo[27]};
          quo <= {quo[26:0], ge};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          r_ppm <= 32'd0;
          if (rs_sat == 24'd0 || two_code == 17'd0) begin
            r_status <= ST_NO_SENSOR;
            if (mode_r) begin
              ref_valid <= 1'b0;
              ref_res   <= 24'd0;
            end
            state <= S_DONE;
          end else if (mode_r) begin
            ref_res   <= rs_sat;
            ref_valid <= 1'b1;
            r_status  <= ST_CALIBRATED;
            state     <= S_DONE;
          end else begin
            if (!ref_valid) begin
              ref_res   <= rs_sat;
              ref_valid <= 1'b1;
            end
            rs        <= rs_sat;
            lp        <= msb24(log_x);
            m         <= 31'(log_x) << (5'd30 - msb24(log_x));
            frac      <= 16'd0;
            cnt       <= 5'd15;
            log_phase <= 1'b0;
            r_status  <= ST_MEASURED;
            state     <= S_LOG;
          end
        end
        S_LOG: begin
          m         <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
          frac      <= {frac[14:0], sq_hi[31]};
          cnt       <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            if (!log_phase) begin
              lr        <= lr_fin;
              log_phase <= 1'b1;
              lp        <= msb24(rs);
              m         <= 31'(rs) << (5'd30 - msb24(rs));
              frac      <= 16'd0;
              cnt       <= 5'd15;
            end else begin
              ls    <= lr_fin;
              state <= S_TMUL;
            end
          end
        end
        S_TMUL: begin
          neg <= t_neg;
          ip  <= t[23:16];
          f   <= t[15:0];
          rr  <= 32'h40000000;
          k   <= 4'd0;
          ef  <= t_neg ? (16'd0 - t[15:0]) : t[15:0];
          if (t_neg && t[15:0] == 16'd0) begin
            state <= S_MUL;
          end else begin
            state <= S_EXP_INIT;
          end
        end
        S_EXP_INIT: begin
          rad   <= 64'(ev) << 30;
          res   <= 64'd0;
          bitv  <= 64'd1 << 62;
          cnt   <= 5'd15;
          state <= S_EXP;
        end
        S_EXP: begin
          rad  <= rad_b;
          res  <= res_b;
          bitv <= bitv >> 4;
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            rr <= res_b[31:0];
            k  <= k + 4'd1;
            state <= (k == 4'd15) ? S_MUL : S_EXP_INIT;
          end
        end
        S_MUL: begin
          prod  <= 46'(cfg.cal_ppm) * 46'(rr);
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          r_ppm <= ppm_val;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_ppm    <= r_ppm;
            out_status <= r_status;
            out_cal    <= ref_valid;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/gas_sensor_ppm_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter
// A measured sample takes 28 divide steps, 32 log2 squarings and up to 16
// square roots; a calibration takes only the divide steps, and a no-sensor
// item caught at the input skips the compute.
// Throughput: one item per compute pass of the sequencer; a two-entry input
// queue and an output register let both sides stall independently.
// Reset clears the reference, the queues and restores register defaults.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_converter import gsp_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                mode,
  input  logic [ADC_BITS-1:0] adc_code,
  input  logic                read_failed,
  output logic                empty,
  input  logic                pop,
  output logic [31:0]         ppm_q8,
  output logic [1:0]          status,
  output logic                is_calibrated,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_data
);

  logic [9:0] min_valid_code;
  cfg_t       cfg;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  logic       out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid_code         <= RST_MIN_VALID_CODE;
      cfg.cal_ppm            <= RST_CAL_PPM;
      cfg.curve_exponent_q12 <= RST_CURVE_EXPONENT;
      cfg.supply_code_x2     <= RST_SUPPLY_CODE_X2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_VALID_CODE: min_valid_code         <= cfg_data[9:0];
        REG_CAL_PPM:        cfg.cal_ppm            <= cfg_data[13:0];
        REG_CURVE_EXPONENT: cfg.curve_exponent_q12 <= cfg_data[14:0];
        REG_SUPPLY_CODE_X2: cfg.supply_code_x2     <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  gsp_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .mode           (mode),
    .adc_code       (adc_code),
    .read_failed    (read_failed),
    .min_valid_code (min_valid_code),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  gsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .out_ppm    (ppm_q8),
    .out_status (status),
    .out_cal    (is_calibrated)
  );

  assign empty = !out_valid;

  a_measured_has_ref: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_MEASURED) |-> is_calibrated)
    else $error("measured result without a reference");

  a_cal_has_ref: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_CALIBRATED) |-> (is_calibrated && ppm_q8 == 32'd0))
    else $error("calibration result inconsistent");

  a_nosensor_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_NO_SENSOR) |-> (ppm_q8 == 32'd0))
    else $error("no-sensor result carries a concentration");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the gas sensor ppm converter. A behavioral
// predictor of the power-law conversion tracks the reference resistance and
// the configuration, and every result transfer is compared with the oldest
// prediction. Directed tests cover the threshold, failed reads, zero
// resistance and calibration; random tests mix calibrations and measurements
// under several register settings with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import gsp_pkg::*;

  typedef struct {
    logic [31:0] ppm_q8;
    logic [1:0]  status;
    logic        is_calibrated;
  } ppm_result_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        mode = 1'b0;
  logic [9:0]  adc_code = '0;
  logic        read_failed = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] ppm_q8;
  logic [1:0]  status;
  logic        is_calibrated;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  logic [9:0]  min_code_r;
  logic [13:0] cal_ppm_r;
  logic [14:0] exponent_r;
  logic [12:0] supply_x2_r;
  logic [23:0] ref_res;
  logic        ref_held;

  ppm_result_t expected_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          stall_on = 1'b0;

  gas_sensor_ppm_converter #(.ADC_BITS(10)) uut (.*);

  always #6 clk = ~clk;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] log2_fx(logic [31:0] x);
    int          p;
    logic [63:0] m;
    logic [15:0] fr;
    p = 0;
    fr = '0;
    while (p < 31 && (x >> (p + 1)) != 0) p++;
    m = 64'(x) << (30 - p);
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr[k] = 1'b1;
      end
    end
    return (32'(p) << 16) | 32'(fr);
  endfunction

  function automatic logic [63:0] exp2_fx(logic [31:0] f);
    logic [63:0] r;
    logic [63:0] v;
    r = 64'd1 << 30;
    for (int k = 0; k < 16; k++) begin
      v = f[k] ? (r << 1) : r;
      r = int_sqrt(v << 30);
    end
    return r;
  endfunction

  function automatic logic [23:0] sensor_resistance(logic [9:0] code);
    logic [63:0] q;
    if (32'(supply_x2_r) <= 2 * 32'(code)) return '0;
    q = (64'(32'(supply_x2_r) - 2 * 32'(code)) << 15) / 64'(code);
    return q > 64'hFFFFFF ? 24'hFFFFFF : q[23:0];
  endfunction

  function automatic logic [31:0] power_law_ppm(logic [23:0] rref, logic [23:0] rs);
    logic [31:0] lr;
    logic [31:0] ls;
    logic        neg;
    logic [63:0] dmag;
    logic [63:0] t;
    logic [63:0] ip;
    logic [31:0] f;
    logic [63:0] val;
    logic [63:0] rsh;
    lr = log2_fx(32'(rref));
    ls = log2_fx(32'(rs));
    neg = lr < ls;
    dmag = neg ? 64'(ls - lr) : 64'(lr - ls);
    t = (dmag * 64'(exponent_r)) >> 12;
    ip = t >> 16;
    f = 32'(t[15:0]);
    if (!neg) begin
      val = 64'(cal_ppm_r) * exp2_fx(f);
      if (val == 0) return '0;
      if (ip >= 22) begin
        if (ip - 22 >= 19) return 32'hFFFFFFFF;
        val = val << (ip - 22);
      end else begin
        val = val >> (22 - ip);
      end
    end else begin
      if (f == 0) begin
        val = 64'(cal_ppm_r) << 30;
        rsh = 22 + ip;
      end else begin
        val = 64'(cal_ppm_r) * exp2_fx(32'd65536 - f);
        rsh = 23 + ip;
      end
      val = rsh >= 64 ? 64'd0 : (val >> rsh);
    end
    return val > 64'hFFFFFFFF ? 32'hFFFFFFFF : val[31:0];
  endfunction

  function automatic ppm_result_t predict_reading(logic m, logic [9:0] code, logic bad);
    ppm_result_t r;
    logic [23:0] rs;
    logic        ok;
    ok = !bad && code > min_code_r;
    rs = ok ? sensor_resistance(code) : '0;
    r.ppm_q8 = '0;
    if (!ok || rs == 0) begin
      r.status = ST_NO_SENSOR;
      if (m) begin
        ref_res = '0;
        ref_held = 1'b0;
      end
    end else if (m) begin
      ref_res = rs;
      ref_held = 1'b1;
      r.status = ST_CALIBRATED;
    end else begin
      if (!ref_held) begin
        ref_res = rs;
        ref_held = 1'b1;
      end
      r.ppm_q8 = power_law_ppm(ref_res, rs);
      r.status = ST_MEASURED;
    end
    r.is_calibrated = ref_held;
    return r;
  endfunction

  task automatic send_reading(logic m, logic [9:0] code, logic bad);
    mode = m;
    adc_code = code;
    read_failed = bad;
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_q.push_back(predict_reading(m, code, bad));
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic random_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_MIN_VALID_CODE: min_code_r = val[9:0];
      REG_CAL_PPM:        cal_ppm_r = val[13:0];
      REG_CURVE_EXPONENT: exponent_r = val;
      default:            supply_x2_r = val[12:0];
    endcase
  endtask

  task automatic set_config(logic [9:0] mn, logic [13:0] cp, logic [14:0] ex,
                            logic [12:0] sx);
    wait_drained();
    write_reg(REG_MIN_VALID_CODE, 15'(mn));
    write_reg(REG_CAL_PPM, 15'(cp));
    write_reg(REG_CURVE_EXPONENT, ex);
    write_reg(REG_SUPPLY_CODE_X2, 15'(sx));
  endtask

  task automatic test_directed();
    send_reading(1'b0, 10'd300, 1'b0);
    send_reading(1'b0, 10'd200, 1'b0);
    send_reading(1'b0, 10'd800, 1'b0);
    send_reading(1'b0, 10'd15, 1'b0);
    send_reading(1'b0, 10'd16, 1'b0);
    send_reading(1'b0, 10'd0, 1'b0);
    send_reading(1'b0, 10'd1023, 1'b0);
    send_reading(1'b0, 10'd400, 1'b1);
    send_reading(1'b1, 10'd1023, 1'b0);
    send_reading(1'b0, 10'd1023, 1'b0);
    send_reading(1'b0, 10'd600, 1'b0);
    send_reading(1'b1, 10'd16, 1'b0);
    send_reading(1'b0, 10'd1000, 1'b0);
    send_reading(1'b0, 10'd16, 1'b0);
    send_reading(1'b1, 10'd500, 1'b1);
    send_reading(1'b0, 10'd500, 1'b0);
    send_reading(1'b1, 10'd10, 1'b0);
    send_reading(1'b1, 10'd512, 1'b0);
    send_reading(1'b0, 10'd511, 1'b0);
    send_reading(1'b0, 10'd700, 1'b0);
  endtask

  task automatic test_extreme_config();
    set_config(10'd0, 14'd16383, 15'd32767, 13'd8191);
    send_reading(1'b1, 10'd1, 1'b0);
    send_reading(1'b0, 10'd1023, 1'b0);
    send_reading(1'b0, 10'd1, 1'b0);
    send_reading(1'b0, 10'd0, 1'b0);
    send_reading(1'b1, 10'd1023, 1'b0);
    send_reading(1'b0, 10'd1, 1'b0);
    set_config(10'd1023, 14'd0, 15'd0, 13'd0);
    send_reading(1'b0, 10'd1023, 1'b0);
    set_config(10'd2, 14'd0, 15'd0, 13'd4000);
    send_reading(1'b1, 10'd100, 1'b0);
    send_reading(1'b0, 10'd900, 1'b0);
  endtask

  task automatic test_random(int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0)
        send_reading(1'b1, 10'($urandom_range(0, 1023)), $urandom_range(0, 7) == 0);
      else
        send_reading(1'b0, 10'($urandom_range(0, 1023)), $urandom_range(0, 15) == 0);
      n++;
      if ($urandom_range(0, 7) == 0) random_gap();
    end
  endtask

  always @(negedge clk) begin
    if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
    pop <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    ppm_result_t e;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer ppm=%h", ppm_q8);
      end else begin
        e = expected_q.pop_front();
        if (ppm_q8 !== e.ppm_q8 || status !== e.status ||
            is_calibrated !== e.is_calibrated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ppm=%h st=%0d cal=%0d, got ppm=%h st=%0d cal=%0d",
                     e.ppm_q8, e.status, e.is_calibrated, ppm_q8, status, is_calibrated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    min_code_r = RST_MIN_VALID_CODE;
    cal_ppm_r = RST_CAL_PPM;
    exponent_r = RST_CURVE_EXPONENT;
    supply_x2_r = RST_SUPPLY_CODE_X2;
    ref_res = '0;
    ref_held = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_extreme_config();
    set_config(10'd15, 14'd20, 15'd8495, 13'd3103);
    test_random(300);
    set_config(10'($urandom_range(0, 100)), 14'($urandom_range(1, 10000)),
               15'($urandom_range(1, 32767)), 13'($urandom_range(2048, 8191)));
    test_random(300);
    set_config(10'd1, 14'd10000, 15'd1, 13'd2048);
    test_random(300);
    wait_drained();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gsp_pkg.sv
rtl/gsp_front.sv
rtl/gsp_back.sv
rtl/gas_sensor_ppm_converter.sv
verif/tb_top.sv
